// ===== hw/rtl/blagd_pkg.sv =====
package blagd_pkg;

    localparam int DEPTH = 8;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int CMP_W = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int DATA_W = 8;
    localparam int COUNT_W = 4;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [DATA_W-1:0] NO_DATA = 8'hff;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [COUNT_W-1:0] count_of(input logic [FILL_W-1:0] fill);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(fill);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/blagd_if.sv =====
interface blagd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] value;
    logic [3:0] position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink (input valid, input command, input value, input position,
                  output ready);
endinterface

interface blagd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       ok;
    logic [3:0] count;

    modport source (output valid, output data, output ok, output count, input ready);
    modport sink (input valid, input data, input ok, input count, output ready);
endinterface

// ===== hw/rtl/blagd_cell.sv =====
module blagd_cell (
    input  logic                               clk,
    input  blagd_pkg::cell_ctrl_t              ctrl,
    input  logic [blagd_pkg::DATA_W-1:0]       value,
    input  logic [blagd_pkg::DATA_W-1:0]       next_data,
    output logic [blagd_pkg::DATA_W-1:0]       data
);
    import blagd_pkg::*;

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= value;
        end
        else if (ctrl.shift)
        begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;
endmodule

// ===== hw/rtl/byte_list_append_get_delete.sv =====
// channel  dir  handshake     payload
// cmd      in   valid/ready   command, value, position
// rsp      out  valid/ready   data, ok, count
//
// the command updates the cell row and the registered response in the cycle it is
// accepted, delete shifts all cells at or above the given position at once
// a new command is taken whenever the response register is empty or being drained
// rst_n clears the fill level and the response valid; cell contents are left as is
// a stalled response holds its value and blocks only further commands
module byte_list_append_get_delete (
    input  logic        clk,
    input  logic        rst_n,
    blagd_cmd_if.sink   cmd,
    blagd_rsp_if.source rsp
);
    import blagd_pkg::*;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               valid_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  data_next;
    logic               ok_reg;
    logic               ok_next;
    logic [COUNT_W-1:0] count_reg;

    logic               accept;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   fill_ext;
    logic               pos_ok;
    logic               room;
    logic [DATA_W-1:0]  rd_data;
    logic               do_append;
    logic               do_delete;

    logic [DATA_W-1:0]  cell_data [DEPTH];
    cell_ctrl_t         cell_ctrl [DEPTH];

    assign cmd.ready = !valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign pos_ext  = CMP_W'(cmd.position);
    assign fill_ext = CMP_W'(fill_reg);
    assign pos_ok   = (pos_ext < fill_ext) && (pos_ext < CMP_W'(DEPTH));
    assign room     = fill_reg < FILL_W'(DEPTH);

    assign do_append = accept && (cmd.command == CMD_APPEND) && room;
    assign do_delete = accept && (cmd.command == CMD_DELETE) && pos_ok;

    always_comb
    begin
        rd_data = NO_DATA;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pos_ext == CMP_W'(i))
            begin
                rd_data = cell_data[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
        logic [DATA_W-1:0] next_data;

        if (g == DEPTH - 1)
        begin : g_last
            assign next_data = NO_DATA;
        end
        else
        begin : g_mid
            assign next_data = cell_data[g+1];
        end

        assign cell_ctrl[g].load  = do_append && (fill_ext == IDX);
        assign cell_ctrl[g].shift = do_delete && (IDX >= pos_ext);

        blagd_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl[g]),
            .value     (cmd.value),
            .next_data (next_data),
            .data      (cell_data[g])
        );
    end

    always_comb
    begin
        fill_next = fill_reg;
        data_next = NO_DATA;
        ok_next   = 1'b0;
        unique case (cmd.command)
            CMD_APPEND:
            begin
                ok_next = room;
                if (room)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            CMD_READ:
            begin
                ok_next = pos_ok;
                if (pos_ok)
                begin
                    data_next = rd_data;
                end
            end
            CMD_DELETE:
            begin
                ok_next = pos_ok;
                if (pos_ok)
                begin
                    data_next = rd_data;
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                ok_next   = 1'b1;
                fill_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg  <= fill_next;
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= data_next;
            ok_reg    <= ok_next;
            count_reg <= count_of(fill_next);
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;
    assign rsp.ok    = ok_reg;
    assign rsp.count = count_reg;
endmodule
